### rtl/core/mlnp_pkg.sv
// Shared types and constants for the monophonic last-note-priority key engine.
`timescale 1ns / 1ps
`default_nettype none

package mlnp_pkg;

  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int CHAN_W     = 4;
  localparam int NOTE_COUNT = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_PATH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTS_INT  = 2'd2;

  // Key event codes.
  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic              from_internal;
    logic [NOTE_W-1:0] key_number;
    logic [VEL_W-1:0]  key_velocity;
    logic [CHAN_W-1:0] key_channel;
  } req_t;

  typedef struct packed {
    logic              gate_on;
    logic [NOTE_W-1:0] out_note;
    logic [VEL_W-1:0]  out_velocity;
    logic [CHAN_W-1:0] out_channel;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic meta_rd;
    logic stack_upd;
    logic oc_cap;
    logic idx_clr;
    logic idx_inc;
    logic pos_cap;
    logic idx_drop;
    logic drop_first;
    logic shift_wr;
    logic cnt_dec;
    logic append;
    logic idx_top;
    logic snd_top;
    logic snd_clr;
    logic out_load;
    logic out_retrig;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic internal;
    logic mono;
    logic path_en;
    logic accepts;
    logic match;
    logic idx_end;
    logic full;
    logic cnt_zero;
    logic snd_hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/mlnp_chan_stack.sv
// Per-note channel stack kept as a ring buffer in memory, with a base and fill per note.
`timescale 1ns / 1ps
`default_nettype none

module mlnp_chan_stack import mlnp_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NOTE_W-1:0] note,
  input  logic [CHAN_W-1:0] channel,
  input  logic              is_pop,
  input  logic              meta_rd,
  input  logic              upd,
  input  logic              cap,
  output logic [CHAN_W-1:0] oc
);

  localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int MW    = SW + FW;
  localparam int SLOTS = NOTE_COUNT * (2 ** SW);
  localparam logic [FW:0]   DEPTH_S = (FW + 1)'(DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

  logic [CHAN_W-1:0]     chan_mem [SLOTS];
  logic [MW-1:0]         meta_mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] meta_ok;

  logic [MW-1:0]     meta_rdata;
  logic              meta_hit;
  logic [CHAN_W-1:0] chan_rdata;
  logic              pop_hit;

  logic [SW-1:0] base;
  logic [FW-1:0] fill;
  logic [FW:0]   push_sum;
  logic [FW:0]   pop_sum;
  logic [FW:0]   base_inc;
  logic [SW-1:0] push_slot;
  logic [SW-1:0] pop_slot;
  logic [SW-1:0] base_next;
  logic [FW-1:0] fill_next;
  logic          full;
  logic          empty;

  // A note whose entry was never written has an empty stack.
  assign base  = meta_hit ? meta_rdata[MW-1:FW] : '0;
  assign fill  = meta_hit ? meta_rdata[FW-1:0] : '0;
  assign full  = (fill == DEPTH_F);
  assign empty = (fill == '0);

  // Ring positions: the top sits at base + fill - 1; a push when full overwrites the oldest.
  assign push_sum  = (FW + 1)'(base) + (FW + 1)'(fill);
  assign pop_sum   = push_sum - (FW + 1)'(1);
  assign base_inc  = (FW + 1)'(base) + (FW + 1)'(1);
  assign push_slot = (push_sum >= DEPTH_S) ? SW'(push_sum - DEPTH_S) : SW'(push_sum);
  assign pop_slot  = (pop_sum >= DEPTH_S) ? SW'(pop_sum - DEPTH_S) : SW'(pop_sum);

  always_comb begin
    base_next = base;
    fill_next = fill;
    if (is_pop) begin
      if (!empty) begin
        fill_next = fill - FW'(1);
      end
    end else if (full) begin
      base_next = (base_inc >= DEPTH_S) ? '0 : SW'(base_inc);
    end else begin
      fill_next = fill + FW'(1);
    end
  end

  // Written-entry flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_ok <= '0;
    end else if (upd) begin
      meta_ok[note] <= 1'b1;
    end
  end

  // Memories and read registers.
  always_ff @(posedge clk) begin
    if (meta_rd) begin
      meta_rdata <= meta_mem[note];
      meta_hit   <= meta_ok[note];
    end
    if (upd) begin
      meta_mem[note] <= {base_next, fill_next};
      if (!is_pop) begin
        chan_mem[{note, push_slot}] <= channel;
      end
      chan_rdata <= chan_mem[{note, pop_slot}];
      pop_hit    <= is_pop && !empty;
    end
    if (cap) begin
      oc <= pop_hit ? chan_rdata : channel;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mlnp_datapath.sv
// Datapath: request and config registers, held-note list, sounding note and result register.
`timescale 1ns / 1ps
`default_nettype none

module mlnp_datapath import mlnp_pkg::*; #(
  parameter int HELD_DEPTH          = 8,
  parameter int CHANNEL_STACK_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data
);

  localparam int IW = $clog2(HELD_DEPTH);
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HELD_DEPTH);

  req_t              req;
  logic              mono_mode;
  logic              note_path_enabled;
  logic              accepts_internal;
  logic [NOTE_W-1:0] held_note [HELD_DEPTH];
  logic [VEL_W-1:0]  held_vel  [HELD_DEPTH];
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [IW-1:0]     pos;
  logic              snd_valid;
  logic [NOTE_W-1:0] snd_note;
  logic [CHAN_W-1:0] oc;

  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     shift_idx;
  logic [NOTE_W-1:0] rd_note;
  logic [VEL_W-1:0]  rd_vel;
  logic              rel;

  assign rel       = (req.cmd == CMD_RELEASE);
  assign rd_idx    = idx[IW-1:0];
  assign shift_idx = IW'(idx - CW'(1));
  assign rd_note   = held_note[rd_idx];
  assign rd_vel    = held_vel[rd_idx];

  // Channel bookkeeping for every request.
  mlnp_chan_stack #(
    .DEPTH(CHANNEL_STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .note    (req.key_number),
    .channel (req.key_channel),
    .is_pop  (rel),
    .meta_rd (cmd.meta_rd),
    .upd     (cmd.stack_upd),
    .cap     (cmd.oc_cap),
    .oc      (oc)
  );

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode         <= 1'b0;
      note_path_enabled <= 1'b1;
      accepts_internal  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MONO_MODE:   mono_mode         <= cfg_data[0];
        CFG_NOTE_PATH:   note_path_enabled <= cfg_data[0];
        CFG_ACCEPTS_INT: accepts_internal  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Held-list entries: shift one slot down, or append at the top.
  always_ff @(posedge clk) begin
    if (cmd.shift_wr) begin
      held_note[shift_idx] <= rd_note;
      held_vel[shift_idx]  <= rd_vel;
    end else if (cmd.append) begin
      held_note[count[IW-1:0]] <= req.key_number;
      held_vel[count[IW-1:0]]  <= req.key_velocity;
    end
  end

  // Scan index and the position of a found note.
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (cmd.idx_drop) begin
      idx <= cmd.drop_first ? CW'(1) : CW'(pos) + CW'(1);
    end else if (cmd.idx_top) begin
      idx <= count - CW'(1);
    end
    if (cmd.pos_cap) begin
      pos <= rd_idx;
    end
  end

  // Fill count and sounding note.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      snd_valid <= 1'b0;
      snd_note  <= '0;
    end else begin
      if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end else if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.append) begin
        snd_valid <= 1'b1;
        snd_note  <= req.key_number;
      end else if (cmd.snd_top) begin
        snd_valid <= 1'b1;
        snd_note  <= rd_note;
      end else if (cmd.snd_clr) begin
        snd_valid <= 1'b0;
        snd_note  <= '0;
      end
    end
  end

  // Result register, free again once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_retrig) begin
        out_data.gate_on      <= 1'b1;
        out_data.out_note     <= rd_note;
        out_data.out_velocity <= rd_vel;
        out_data.out_channel  <= oc;
      end else begin
        out_data.gate_on      <= !rel;
        out_data.out_note     <= req.key_number;
        out_data.out_velocity <= rel ? '0 : req.key_velocity;
        out_data.out_channel  <= rel ? oc : req.key_channel;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    status.is_release = rel;
    status.internal   = req.from_internal;
    status.mono       = mono_mode;
    status.path_en    = note_path_enabled;
    status.accepts    = accepts_internal;
    status.match      = (rd_note == req.key_number);
    status.idx_end    = (idx >= count);
    status.full       = (count == DEPTH_C);
    status.cnt_zero   = (count == '0);
    status.snd_hit    = snd_valid && (snd_note == req.key_number);
    status.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

### rtl/core/mlnp_ctrl.sv
// Controller state machine that sequences stack update, list search, shift and result.
`timescale 1ns / 1ps
`default_nettype none

module mlnp_ctrl import mlnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_STACK,
    ST_POP,
    ST_SCAN,
    ST_DROP,
    ST_SHIFT,
    ST_AFTER,
    ST_TOP,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   found;
  logic   found_next;
  logic   snd_was;
  logic   snd_was_next;
  logic   retrig;
  logic   retrig_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    found_next     = found;
    snd_was_next   = snd_was;
    retrig_next    = retrig;
    cmd            = '0;
    cmd.out_retrig = retrig;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_META;
        end
      end
      ST_META: begin
        cmd.meta_rd = 1'b1;
        state_next  = ST_STACK;
      end
      ST_STACK: begin
        cmd.stack_upd = 1'b1;
        state_next    = ST_POP;
      end
      ST_POP: begin
        cmd.oc_cap = 1'b1;
        if (!status.internal || !status.path_en ||
            (!status.is_release && !status.accepts)) begin
          state_next = ST_IDLE;
        end else if (!status.mono) begin
          retrig_next = 1'b0;
          state_next  = ST_EMIT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.idx_end) begin
          found_next = 1'b0;
          state_next = ST_DROP;
        end else if (status.match) begin
          cmd.pos_cap = 1'b1;
          found_next  = 1'b1;
          state_next  = ST_DROP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_DROP: begin
        if (status.is_release) begin
          if (!found) begin
            state_next = ST_IDLE;
          end else begin
            snd_was_next = status.snd_hit;
            cmd.idx_drop = 1'b1;
            state_next   = ST_SHIFT;
          end
        end else if (found) begin
          cmd.idx_drop = 1'b1;
          state_next   = ST_SHIFT;
        end else if (status.full) begin
          // Full list with a new note: the oldest entry goes.
          cmd.idx_drop   = 1'b1;
          cmd.drop_first = 1'b1;
          state_next     = ST_SHIFT;
        end else begin
          state_next = ST_AFTER;
        end
      end
      ST_SHIFT: begin
        if (status.idx_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_AFTER;
        end else begin
          cmd.shift_wr = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      ST_AFTER: begin
        if (!status.is_release) begin
          cmd.append  = 1'b1;
          retrig_next = 1'b0;
          state_next  = ST_EMIT;
        end else if (!snd_was) begin
          state_next = ST_IDLE;
        end else if (status.cnt_zero) begin
          cmd.snd_clr = 1'b1;
          retrig_next = 1'b0;
          state_next  = ST_EMIT;
        end else begin
          cmd.idx_top = 1'b1;
          state_next  = ST_TOP;
        end
      end
      ST_TOP: begin
        // The newest held note sounds again.
        cmd.snd_top = 1'b1;
        retrig_next = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and flag registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      found   <= 1'b0;
      snd_was <= 1'b0;
      retrig  <= 1'b0;
    end else begin
      state   <= state_next;
      found   <= found_next;
      snd_was <= snd_was_next;
      retrig  <= retrig_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mono_last_note_priority.sv
// Top level of the monophonic last-note-priority key engine.
// Flow: a pass-through request moves through the META, STACK, POP and EMIT states, and
// the result register is loaded in EMIT; a mono request adds a list scan (SCAN), a drop
// and shift (DROP, SHIFT) and bookkeeping states (AFTER, TOP) before it reaches EMIT.
// Throughput: one request at a time, taken the cycle after the result register is loaded;
// a result the receiver has not yet taken holds the engine. Reset clears the held count,
// sounding note, channel stack fills and the config registers.
`timescale 1ns / 1ps
`default_nettype none

module mono_last_note_priority import mlnp_pkg::*; #(
  parameter int HELD_DEPTH          = 8,
  parameter int CHANNEL_STACK_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  mlnp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and result path.
  mlnp_datapath #(
    .HELD_DEPTH          (HELD_DEPTH),
    .CHANNEL_STACK_DEPTH (CHANNEL_STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
